@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked through reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/rlfb_pkg.sv @@
// Shared constants, command codes and memory control type for the pixel frame buffer.
`default_nettype none

package rlfb_pkg;

    localparam int NUM_PIXELS_DEF = 64;
    localparam int COLOR_W        = 24;

    localparam logic [3:0] CMD_SET    = 4'd0;
    localparam logic [3:0] CMD_RESET  = 4'd1;
    localparam logic [3:0] CMD_READ   = 4'd2;
    localparam logic [3:0] CMD_TOGGLE = 4'd3;
    localparam logic [3:0] CMD_SHOW   = 4'd4;
    localparam logic [3:0] CMD_ALLOFF = 4'd5;
    localparam logic [3:0] CMD_CLEAR  = 4'd6;
    localparam logic [3:0] CMD_INVERT = 4'd7;
    localparam logic [3:0] CMD_FILL   = 4'd8;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr_all;
    } t_mem_ctl;

endpackage

`default_nettype wire

@@ rtl/rlfb_store.sv @@
// Pixel store: one write port, one registered read port, per-entry valid bits.
`default_nettype none

module rlfb_store #(
    parameter  int NUM_PIXELS = rlfb_pkg::NUM_PIXELS_DEF,
    localparam int AW         = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rlfb_pkg::t_mem_ctl          i_ctl,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [rlfb_pkg::COLOR_W-1:0] i_wcolor,
    input  wire logic                        i_wflag,
    input  wire logic [AW-1:0]               i_raddr,
    output logic      [rlfb_pkg::COLOR_W-1:0] o_rcolor,
    output logic                             o_rflag
);

    logic [rlfb_pkg::COLOR_W:0]   r_mem [NUM_PIXELS];
    logic [NUM_PIXELS-1:0]        r_vld;
    logic [rlfb_pkg::COLOR_W:0]   r_rdata;
    logic                         r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= {i_wflag, i_wcolor};
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_ctl.clr_all) begin
                r_vld <= '0;
            end else if (i_ctl.wr_en) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rcolor = r_rvld ? r_rdata[rlfb_pkg::COLOR_W-1:0] : '0;
    assign o_rflag  = r_rvld & r_rdata[rlfb_pkg::COLOR_W];

endmodule

`default_nettype wire

@@ rtl/rlfb_engine.sv @@
// Command sequencer: decodes commands, walks the store and drives the result register.
`default_nettype none

module rlfb_engine #(
    parameter  int NUM_PIXELS = rlfb_pkg::NUM_PIXELS_DEF,
    localparam int AW         = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [3:0]                   i_cmd,
    input  wire logic [7:0]                   i_position,
    input  wire logic [7:0]                   i_range_end,
    input  wire logic [rlfb_pkg::COLOR_W-1:0] i_rgb,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [rlfb_pkg::COLOR_W-1:0]      o_rgb,
    output logic                              o_lit,
    output logic                              o_last,
    output rlfb_pkg::t_mem_ctl                o_ctl,
    output logic [AW-1:0]                     o_waddr,
    output logic [rlfb_pkg::COLOR_W-1:0]      o_wcolor,
    output logic                              o_wflag,
    output logic [AW-1:0]                     o_raddr,
    input  wire logic [rlfb_pkg::COLOR_W-1:0] i_rcolor,
    input  wire logic                         i_rflag
);

    localparam int CW = AW + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_TOGGLE = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;

    localparam logic [1:0] MODE_SHOW   = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_FIND   = 2'd2;
    localparam logic [1:0] MODE_INVERT = 2'd3;

    localparam logic [7:0]    POS_LIMIT = 8'(NUM_PIXELS);
    localparam logic [CW-1:0] IDX_END   = CW'(NUM_PIXELS);
    localparam logic [CW-1:0] IDX_LAST  = CW'(NUM_PIXELS - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(NUM_PIXELS - 1);

    logic [2:0]                    r_state, n_state;
    logic [1:0]                    r_mode, n_mode;
    logic [CW-1:0]                 r_idx, n_idx;
    logic [AW-1:0]                 r_pidx, n_pidx;
    logic                          r_pend, n_pend;
    logic [rlfb_pkg::COLOR_W-1:0]  r_pick, n_pick;
    logic [7:0]                    r_pos, n_pos;
    logic [7:0]                    r_end, n_end;
    logic [rlfb_pkg::COLOR_W-1:0]  r_rgb, n_rgb;
    logic                          r_out_valid;
    logic [rlfb_pkg::COLOR_W-1:0]  r_out_rgb;
    logic                          r_out_lit;
    logic                          r_out_last;

    logic                          load_out;
    logic [rlfb_pkg::COLOR_W-1:0]  out_rgb;
    logic                          out_lit;
    logic                          out_last;
    logic                          out_free;
    logic                          pos_ok;
    logic                          found;
    logic [7:0]                    idx8;

    assign o_ready  = (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_ready;
    assign pos_ok   = (i_position < POS_LIMIT);
    assign idx8     = 8'(r_idx);

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pend   = r_pend;
        n_pick   = r_pick;
        n_pos    = r_pos;
        n_end    = r_end;
        n_rgb    = r_rgb;
        o_ctl    = '0;
        o_waddr  = r_pidx;
        o_wcolor = '0;
        o_wflag  = 1'b0;
        o_raddr  = r_idx[AW-1:0];
        load_out = 1'b0;
        out_rgb  = i_rcolor;
        out_lit  = i_rflag;
        out_last = 1'b1;
        found    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_cmd)
                        rlfb_pkg::CMD_SET: begin
                            o_ctl.wr_en = pos_ok;
                            o_waddr     = i_position[AW-1:0];
                            o_wcolor    = i_rgb;
                            o_wflag     = (i_rgb != '0);
                        end
                        rlfb_pkg::CMD_RESET: begin
                            o_ctl.wr_en = pos_ok;
                            o_waddr     = i_position[AW-1:0];
                        end
                        rlfb_pkg::CMD_READ, rlfb_pkg::CMD_TOGGLE: begin
                            if (pos_ok) begin
                                o_ctl.rd_en = 1'b1;
                                o_raddr     = i_position[AW-1:0];
                                n_pidx      = i_position[AW-1:0];
                                n_state     = (i_cmd == rlfb_pkg::CMD_READ) ? ST_READ
                                                                            : ST_TOGGLE;
                            end
                        end
                        rlfb_pkg::CMD_SHOW, rlfb_pkg::CMD_ALLOFF: begin
                            o_ctl.clr_all = (i_cmd == rlfb_pkg::CMD_ALLOFF);
                            n_mode  = MODE_SHOW;
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = ST_WALK;
                        end
                        rlfb_pkg::CMD_CLEAR: begin
                            n_mode  = MODE_CLEAR;
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = ST_WALK;
                        end
                        rlfb_pkg::CMD_INVERT: begin
                            n_mode  = MODE_FIND;
                            n_pick  = '0;
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = ST_WALK;
                        end
                        rlfb_pkg::CMD_FILL: begin
                            n_pos   = i_position;
                            n_end   = i_range_end;
                            n_rgb   = i_rgb;
                            n_idx   = '0;
                            n_state = ST_FILL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_TOGGLE: begin
                o_ctl.wr_en = 1'b1;
                o_wcolor    = i_rcolor;
                o_wflag     = !i_rflag;
                n_state     = ST_IDLE;
            end
            ST_WALK: begin
                if (!(r_pend && (r_mode == MODE_SHOW) && !out_free)) begin
                    if (r_pend) begin
                        case (r_mode)
                            MODE_SHOW: begin
                                load_out = 1'b1;
                                out_rgb  = i_rflag ? i_rcolor : '0;
                                out_last = (r_pidx == ADDR_LAST);
                            end
                            MODE_CLEAR: begin
                                o_ctl.wr_en = 1'b1;
                                o_wcolor    = i_rcolor;
                            end
                            MODE_FIND: begin
                                if (i_rflag) begin
                                    n_pick = i_rcolor;
                                    found  = 1'b1;
                                end
                            end
                            MODE_INVERT: begin
                                o_ctl.wr_en = 1'b1;
                                o_wcolor    = i_rflag ? '0 : r_pick;
                                o_wflag     = !i_rflag && (r_pick != '0);
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (found) begin
                        n_mode = MODE_INVERT;
                        n_idx  = '0;
                        n_pend = 1'b0;
                    end else if (r_idx != IDX_END) begin
                        o_ctl.rd_en = 1'b1;
                        n_pidx      = r_idx[AW-1:0];
                        n_idx       = r_idx + CW'(1);
                        n_pend      = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                        if (r_mode == MODE_FIND) begin
                            n_mode = MODE_INVERT;
                            n_idx  = '0;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_FILL: begin
                o_waddr     = r_idx[AW-1:0];
                o_wcolor    = r_rgb;
                o_wflag     = (r_rgb != '0);
                o_ctl.wr_en = (idx8 >= r_pos) && (idx8 <= r_end);
                n_idx       = r_idx + CW'(1);
                if (r_idx == IDX_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_SHOW;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx;
        r_pick <= n_pick;
        r_pos  <= n_pos;
        r_end  <= n_end;
        r_rgb  <= n_rgb;
        if (load_out) begin
            r_out_rgb  <= out_rgb;
            r_out_lit  <= out_lit;
            r_out_last <= out_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rgb   = r_out_rgb;
    assign o_lit   = r_out_lit;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/rgb_led_frame_buffer.sv @@
// Top level of the RGB pixel frame buffer: command sequencer over the pixel store.
//
//  channel   direction  handshake            payload
//  command   in         i_valid / o_ready    i_cmd, i_position, i_range_end, i_*_in
//  result    out        o_valid / i_ready    o_red_out, o_green_out, o_blue_out, o_lit, o_last
//
// Set and reset complete in the idle state; read and toggle pass through ST_READ or ST_TOGGLE,
// read also waiting on any result stall. Show and all-off walk every pixel through the read port,
// one pixel per cycle while the result register is free. Clear flags walks every pixel; invert
// scans for the first lit pixel, then rewrites every pixel; range fill walks every index in ST_FILL.
// Commands are taken one at a time. Reset clears the per-pixel valid bits; no clearing pass is needed.
// A full result register stalls show, all-off and read only; o_valid holds until taken.
`default_nettype none

module rgb_led_frame_buffer #(
    parameter int NUM_PIXELS = rlfb_pkg::NUM_PIXELS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [3:0] i_cmd,
    input  wire logic [7:0] i_position,
    input  wire logic [7:0] i_range_end,
    input  wire logic [7:0] i_red_in,
    input  wire logic [7:0] i_green_in,
    input  wire logic [7:0] i_blue_in,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_red_out,
    output logic [7:0]      o_green_out,
    output logic [7:0]      o_blue_out,
    output logic            o_lit,
    output logic            o_last
);

    localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

    rlfb_pkg::t_mem_ctl               mem_ctl;
    logic [AW-1:0]                    waddr;
    logic [AW-1:0]                    raddr;
    logic [rlfb_pkg::COLOR_W-1:0]     wcolor;
    logic                             wflag;
    logic [rlfb_pkg::COLOR_W-1:0]     rcolor;
    logic                             rflag;
    logic [rlfb_pkg::COLOR_W-1:0]     out_rgb;

    rlfb_engine #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_position  (i_position),
        .i_range_end (i_range_end),
        .i_rgb       ({i_red_in, i_green_in, i_blue_in}),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rgb       (out_rgb),
        .o_lit       (o_lit),
        .o_last      (o_last),
        .o_ctl       (mem_ctl),
        .o_waddr     (waddr),
        .o_wcolor    (wcolor),
        .o_wflag     (wflag),
        .o_raddr     (raddr),
        .i_rcolor    (rcolor),
        .i_rflag     (rflag)
    );

    rlfb_store #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mem_ctl),
        .i_waddr  (waddr),
        .i_wcolor (wcolor),
        .i_wflag  (wflag),
        .i_raddr  (raddr),
        .o_rcolor (rcolor),
        .o_rflag  (rflag)
    );

    assign o_red_out   = out_rgb[23:16];
    assign o_green_out = out_rgb[15:8];
    assign o_blue_out  = out_rgb[7:0];

endmodule

`default_nettype wire

@@ rtl/rlfb_checker.sv @@
// Port-level checker for the pixel frame buffer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rlfb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [3:0] i_cmd,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_red_out,
    input wire logic [7:0] o_green_out,
    input wire logic [7:0] o_blue_out,
    input wire logic       o_lit,
    input wire logic       o_last
);

    `ASSERT_NEXT_ALWAYS(a_no_beat_after_reset, i_clk, !i_rst_n, !o_valid)

    `ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable({o_red_out, o_green_out, o_blue_out, o_lit, o_last}))

    `ASSERT_NEXT(a_set_single_cycle, i_clk, i_rst_n, i_valid && o_ready && (i_cmd == rlfb_pkg::CMD_SET || i_cmd == rlfb_pkg::CMD_RESET), o_ready)

    `ASSERT_NEXT(a_show_busy, i_clk, i_rst_n, i_valid && o_ready && (i_cmd == rlfb_pkg::CMD_SHOW || i_cmd == rlfb_pkg::CMD_ALLOFF), !o_ready)

    `ASSERT_NOW(a_dark_show_black, i_clk, i_rst_n, o_valid && !o_lit && !o_ready && !o_last, o_red_out == 8'd0 && o_green_out == 8'd0 && o_blue_out == 8'd0)

endmodule

bind rgb_led_frame_buffer rlfb_checker u_rlfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_cmd       (i_cmd),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out),
    .o_lit       (o_lit),
    .o_last      (o_last)
);

`default_nettype wire

@@ tb/rgb_led_frame_buffer_tb.sv @@
// Self-checking testbench for the RGB pixel frame buffer: directed table, then random commands.
module rgb_led_frame_buffer_tb;

    localparam int PIXELS = rlfb_pkg::NUM_PIXELS_DEF;
    localparam logic [3:0] CMD_NOP_FIRST = 4'd9;
    localparam logic [3:0] CMD_NOP_LAST  = 4'd15;
    localparam int RANDOM_CMDS  = 450;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       lit;
        logic       last;
    } t_pixel_beat;

    typedef struct {
        logic [3:0]  cmd;
        logic [7:0]  pos;
        logic [7:0]  span_end;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        bit          known;
        t_pixel_beat want;
    } t_frame_cmd;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [3:0] i_cmd;
    logic [7:0] i_position;
    logic [7:0] i_range_end;
    logic [7:0] i_red_in;
    logic [7:0] i_green_in;
    logic [7:0] i_blue_in;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_red_out;
    logic [7:0] o_green_out;
    logic [7:0] o_blue_out;
    logic       o_lit;
    logic       o_last;

    logic [23:0] shadow_rgb [PIXELS];
    bit          shadow_on  [PIXELS];
    t_pixel_beat pending_beats [$];
    t_frame_cmd  directed [$];
    int          fail_count  = 0;
    int          burst_left  = 0;
    int          hold_count  = 0;
    bit          hold_req    = 0;

    rgb_led_frame_buffer #(
        .NUM_PIXELS(PIXELS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (i_cmd),
        .i_position (i_position),
        .i_range_end(i_range_end),
        .i_red_in   (i_red_in),
        .i_green_in (i_green_in),
        .i_blue_in  (i_blue_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_red_out  (o_red_out),
        .o_green_out(o_green_out),
        .o_blue_out (o_blue_out),
        .o_lit      (o_lit),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic store_pixel(input int idx, input logic [23:0] rgb);
        shadow_rgb[idx] = rgb;
        shadow_on[idx]  = (rgb != 24'd0);
    endtask

    task automatic blank_pixel(input int idx);
        shadow_rgb[idx] = 24'd0;
        shadow_on[idx]  = 1'b0;
    endtask

    task automatic emit_frame();
        logic [23:0] rgb;
        for (int i = 0; i < PIXELS; i++) begin
            rgb = shadow_on[i] ? shadow_rgb[i] : 24'd0;
            pending_beats.push_back('{rgb[23:16], rgb[15:8], rgb[7:0], shadow_on[i],
                                      (i == PIXELS - 1)});
        end
    endtask

    task automatic predict_frame_cmd(input t_frame_cmd c);
        logic [23:0] rgb;
        logic [23:0] pick;
        bit          found;
        bit          in_range;
        rgb      = {c.red, c.green, c.blue};
        in_range = (c.pos < PIXELS);
        pick     = 24'd0;
        found    = 1'b0;
        case (c.cmd)
            rlfb_pkg::CMD_SET: begin
                if (in_range) store_pixel(c.pos, rgb);
            end
            rlfb_pkg::CMD_RESET: begin
                if (in_range) blank_pixel(c.pos);
            end
            rlfb_pkg::CMD_READ: begin
                if (in_range)
                    pending_beats.push_back('{shadow_rgb[c.pos][23:16], shadow_rgb[c.pos][15:8],
                                              shadow_rgb[c.pos][7:0], shadow_on[c.pos], 1'b1});
            end
            rlfb_pkg::CMD_TOGGLE: begin
                if (in_range) shadow_on[c.pos] = !shadow_on[c.pos];
            end
            rlfb_pkg::CMD_SHOW: begin
                emit_frame();
            end
            rlfb_pkg::CMD_ALLOFF: begin
                for (int i = 0; i < PIXELS; i++) blank_pixel(i);
                emit_frame();
            end
            rlfb_pkg::CMD_CLEAR: begin
                for (int i = 0; i < PIXELS; i++) shadow_on[i] = 1'b0;
            end
            rlfb_pkg::CMD_INVERT: begin
                for (int i = 0; i < PIXELS; i++) begin
                    if (!found && shadow_on[i]) begin
                        pick  = shadow_rgb[i];
                        found = 1'b1;
                    end
                end
                for (int i = 0; i < PIXELS; i++) begin
                    if (shadow_on[i]) blank_pixel(i);
                    else store_pixel(i, pick);
                end
            end
            rlfb_pkg::CMD_FILL: begin
                for (int i = 0; i < PIXELS; i++)
                    if (i >= c.pos && i <= c.span_end) store_pixel(i, rgb);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_beat();
        t_pixel_beat got;
        t_pixel_beat want;
        got = '{o_red_out, o_green_out, o_blue_out, o_lit, o_last};
        if (pending_beats.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
                $display("unexpected beat: r=%h g=%h b=%h lit=%b last=%b",
                         got.red, got.green, got.blue, got.lit, got.last);
            fail_count++;
        end else begin
            want = pending_beats.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.lit !== want.lit || got.last !== want.last) begin
                if (fail_count < REPORT_LIMIT)
                    $display({"mismatch: exp r=%h g=%h b=%h lit=%b last=%b, ",
                              "got r=%h g=%h b=%h lit=%b last=%b"},
                             want.red, want.green, want.blue, want.lit, want.last,
                             got.red, got.green, got.blue, got.lit, got.last);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) check_beat();
    end

    initial begin
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_count < HOLD_CYCLES) begin
                i_ready = 1'b0;
                hold_count++;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (mode)
                    0: i_ready = 1'b1;
                    1: i_ready = !i_ready;
                    2: i_ready = ($urandom_range(0, 3) != 0);
                    default: i_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic t_frame_cmd cmd_row(input logic [3:0] c, input logic [7:0] p,
                                           input logic [7:0] e, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b);
        t_frame_cmd row;
        row = '{c, p, e, r, g, b, 1'b0, '0};
        return row;
    endfunction

    function automatic t_frame_cmd read_known(input logic [7:0] p, input t_pixel_beat w);
        t_frame_cmd row;
        row = '{rlfb_pkg::CMD_READ, p, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, w};
        return row;
    endfunction

    function automatic t_frame_cmd random_cmd();
        t_frame_cmd c;
        int         sel;
        sel     = $urandom_range(0, 99);
        c.known = 1'b0;
        c.want  = '0;
        if (sel < 30)      c.cmd = rlfb_pkg::CMD_SET;
        else if (sel < 38) c.cmd = rlfb_pkg::CMD_RESET;
        else if (sel < 53) c.cmd = rlfb_pkg::CMD_READ;
        else if (sel < 61) c.cmd = rlfb_pkg::CMD_TOGGLE;
        else if (sel < 66) c.cmd = rlfb_pkg::CMD_SHOW;
        else if (sel < 68) c.cmd = rlfb_pkg::CMD_ALLOFF;
        else if (sel < 72) c.cmd = rlfb_pkg::CMD_CLEAR;
        else if (sel < 77) c.cmd = rlfb_pkg::CMD_INVERT;
        else if (sel < 94) c.cmd = rlfb_pkg::CMD_FILL;
        else               c.cmd = 4'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST));
        c.pos = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, PIXELS - 1))
                                               : 8'($urandom);
        c.span_end = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, PIXELS - 1))
                                                 : 8'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            c.red   = 8'd0;
            c.green = 8'd0;
            c.blue  = 8'd0;
        end else begin
            c.red   = 8'($urandom);
            c.green = 8'($urandom);
            c.blue  = 8'($urandom);
        end
        return c;
    endfunction

    task automatic offer_cmd(input t_frame_cmd c);
        i_cmd       = c.cmd;
        i_position  = c.pos;
        i_range_end = c.span_end;
        i_red_in    = c.red;
        i_green_in  = c.green;
        i_blue_in   = c.blue;
        i_valid     = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (c.known) pending_beats.push_back(c.want);
        else predict_frame_cmd(c);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 10);
        end
    endtask

    initial begin
        t_frame_cmd c;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cmd       = rlfb_pkg::CMD_SET;
        i_position  = 8'd0;
        i_range_end = 8'd0;
        i_red_in    = 8'd0;
        i_green_in  = 8'd0;
        i_blue_in   = 8'd0;
        for (int i = 0; i < PIXELS; i++) begin
            shadow_rgb[i] = 24'd0;
            shadow_on[i]  = 1'b0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed.push_back(read_known(8'd0, '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1}));
        directed.push_back(cmd_row(rlfb_pkg::CMD_SET,    8'd0,   8'd0,   8'hff, 8'hff, 8'hff));
        directed.push_back(read_known(8'd0, '{8'hff, 8'hff, 8'hff, 1'b1, 1'b1}));
        directed.push_back(cmd_row(rlfb_pkg::CMD_SET,    8'd63,  8'd0,   8'haa, 8'h55, 8'h01));
        directed.push_back(cmd_row(rlfb_pkg::CMD_READ,   8'd63,  8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_SET,    8'd5,   8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(read_known(8'd5, '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1}));
        directed.push_back(cmd_row(rlfb_pkg::CMD_SET,    8'd64,  8'd0,   8'h12, 8'h34, 8'h56));
        directed.push_back(cmd_row(rlfb_pkg::CMD_READ,   8'd64,  8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_TOGGLE, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(read_known(8'd0, '{8'hff, 8'hff, 8'hff, 1'b0, 1'b1}));
        directed.push_back(cmd_row(rlfb_pkg::CMD_TOGGLE, 8'd200, 8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_RESET,  8'd255, 8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_RESET,  8'd63,  8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_SHOW,   8'd0,   8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_FILL,   8'd10,  8'd20,  8'h12, 8'h34, 8'h56));
        directed.push_back(cmd_row(rlfb_pkg::CMD_FILL,   8'd30,  8'd10,  8'hff, 8'hff, 8'hff));
        directed.push_back(cmd_row(rlfb_pkg::CMD_FILL,   8'd60,  8'd255, 8'h80, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_INVERT, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_SHOW,   8'd0,   8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_CLEAR,  8'd0,   8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_INVERT, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_SHOW,   8'd0,   8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(rlfb_pkg::CMD_ALLOFF, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00));
        directed.push_back(cmd_row(CMD_NOP_FIRST, 8'd1, 8'd2,  8'h01, 8'h02, 8'h03));
        directed.push_back(cmd_row(CMD_NOP_LAST,  8'd1, 8'd2,  8'h01, 8'h02, 8'h03));

        foreach (directed[k]) offer_cmd(directed[k]);
        i_valid = 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);

        // hold the result side while a frame is in flight
        hold_req = 1'b1;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            c = random_cmd();
            if (n == 0) c.cmd = rlfb_pkg::CMD_SHOW;
            offer_cmd(c);
        end
        i_valid = 1'b0;

        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (2 * PIXELS + 10) @(negedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rlfb_pkg.sv
rtl/rlfb_store.sv
rtl/rlfb_engine.sv
rtl/rgb_led_frame_buffer.sv
rtl/rlfb_checker.sv
tb/rgb_led_frame_buffer_tb.sv
